// ----- sv/lbs_pkg.sv -----
package lbs_pkg;

   localparam int ACC_W   = 48;
   localparam int SUM_W   = 83;
   localparam int ENTRIES = 16;

   // last step of the product walk: 3 rows x 4 columns x 2 halves
   localparam logic [4:0] APPLY_LAST = 5'd23;
   localparam logic [3:0] ENTRY_LAST = 4'd15;

   typedef enum logic {
      OP_LOAD,
      OP_BLEND
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               use_bone;
      logic               last;
      logic [7:0]         bone;
      logic [3:0]         entry;
      logic [31:0]        value;
      logic [15:0]        weight;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_APPLY,
      ST_OUT
   } state_type;

endpackage

// ----- sv/lbs_front.sv -----
module lbs_front #(
   parameter int BONE_COUNT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [7:0]           req_bone_index,
   input  logic [3:0]           req_matrix_entry,
   input  logic signed [31:0]   req_entry_value,
   input  logic [15:0]          req_weight,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic                 req_last_influence,
   output logic                 q_valid,
   output lbs_pkg::cmd_type     q_cmd,
   input  logic                 q_pop
);

   lbs_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             in_range, keep, push, pop;
   lbs_pkg::cmd_type cmd;

   assign in_range = {24'd0, req_bone_index} < 32'(BONE_COUNT);
   // out-of-range loads and inert influences never reach the back end
   assign keep = req_type ? (in_range || req_last_influence) : in_range;

   always_comb begin
      cmd.op       = req_type ? lbs_pkg::OP_BLEND : lbs_pkg::OP_LOAD;
      cmd.use_bone = in_range;
      cmd.last     = req_last_influence;
      cmd.bone     = req_bone_index;
      cmd.entry    = req_matrix_entry;
      cmd.value    = req_entry_value;
      cmd.weight   = req_weight;
      cmd.px       = req_pos_x;
      cmd.py       = req_pos_y;
      cmd.pz       = req_pos_z;
   end

   assign req_ready = cnt_ff != 2'd2;
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = cnt_ff != 2'd0;
   assign pop       = q_pop && q_valid;
   assign q_cmd     = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= cmd;
   end

endmodule

// ----- sv/lbs_back.sv -----
module lbs_back #(
   parameter int BONE_COUNT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  lbs_pkg::cmd_type     q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z
);

   localparam int BW    = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
   localparam int AW    = BW + 4;
   localparam int DEPTH = BONE_COUNT * 16;
   localparam logic signed [32:0] P_ONE = 33'sd1 <<< FRAC_BITS;
   localparam logic signed [lbs_pkg::SUM_W-1:0] SAT_HI = 83'sd2147483647;
   localparam logic signed [lbs_pkg::SUM_W-1:0] SAT_LO = -(83'sd2147483648);

   lbs_pkg::state_type state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   lbs_pkg::cmd_type   cmd_ff;

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] waddr, raddr;
   logic [BW+7:0] qb_ext, cb_ext;

   logic signed [lbs_pkg::ACC_W-1:0] acc_ff [lbs_pkg::ENTRIES];

   logic               rd_vld_ff, mul_vld_ff, prd_vld_ff;
   logic [3:0]         rd_idx_ff, mul_idx_ff;
   logic [4:0]         prd_idx_ff;
   logic signed [48:0] mul_ff;
   logic signed [57:0] prd_ff;
   logic signed [lbs_pkg::SUM_W-1:0] sum_ff, sum_in, contrib, shifted;
   logic signed [31:0] res_ff [3];
   logic signed [31:0] row_sat;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_out_x_ff, rsp_out_y_ff, rsp_out_z_ff;

   logic mem_we, issue, apply_issue, cmd_load, out_load;

   logic [1:0] ap_row, ap_col;
   logic signed [lbs_pkg::ACC_W-1:0] a_sel, acc_m;
   logic signed [24:0] a_op;
   logic signed [32:0] p_op;
   logic signed [33:0] term;
   logic signed [48:0] acc_t;
   logic signed [lbs_pkg::ACC_W-1:0] acc_sat;

   assign qb_ext = {{BW{1'b0}}, q_cmd.bone};
   assign cb_ext = {{BW{1'b0}}, cmd_ff.bone};
   assign waddr  = {qb_ext[BW-1:0], q_cmd.entry};
   assign raddr  = {cb_ext[BW-1:0], cnt_ff[3:0]};

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= q_cmd.value;
      rd_data_ff <= mem[raddr];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      issue       = 1'b0;
      apply_issue = 1'b0;
      cmd_load    = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         lbs_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_cmd.op == lbs_pkg::OP_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  cmd_load = 1'b1;
                  cnt_in   = 5'd0;
                  state_in = q_cmd.use_bone ? lbs_pkg::ST_ACCUM : lbs_pkg::ST_APPLY;
               end
            end
         end
         lbs_pkg::ST_ACCUM: begin
            if (!cnt_ff[4]) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + 5'd1;
            end
            if (mul_vld_ff && mul_idx_ff == lbs_pkg::ENTRY_LAST) begin
               cnt_in   = 5'd0;
               state_in = cmd_ff.last ? lbs_pkg::ST_APPLY : lbs_pkg::ST_IDLE;
            end
         end
         lbs_pkg::ST_APPLY: begin
            if (cnt_ff <= lbs_pkg::APPLY_LAST) begin
               apply_issue = 1'b1;
               cnt_in      = cnt_ff + 5'd1;
            end
            if (prd_vld_ff && prd_idx_ff == lbs_pkg::APPLY_LAST) state_in = lbs_pkg::ST_OUT;
         end
         lbs_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = lbs_pkg::ST_IDLE;
            end
         end
         default: state_in = lbs_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbs_pkg::ST_IDLE;
         cnt_ff       <= 5'd0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         prd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= issue;
         mul_vld_ff   <= rd_vld_ff;
         prd_vld_ff   <= apply_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // blend: weight times bone word, floor-shifted by 15, saturating add
   assign acc_m   = acc_ff[mul_idx_ff];
   assign term    = mul_ff[48:15];
   assign acc_t   = {acc_m[47], acc_m} + {{15{term[33]}}, term};
   assign acc_sat = (acc_t[48] != acc_t[47]) ?
                    (acc_t[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : acc_t[47:0];

   always_ff @(posedge clock) begin
      if (reset || out_load) begin
         for (int i = 0; i < lbs_pkg::ENTRIES; i++) acc_ff[i] <= '0;
      end else if (mul_vld_ff) begin
         acc_ff[mul_idx_ff] <= acc_sat;
      end
   end

   // apply: each accumulator entry split into signed high and unsigned low 24 bits
   assign ap_row = cnt_ff[4:3];
   assign ap_col = cnt_ff[2:1];
   assign a_sel  = acc_ff[{ap_col, ap_row}];
   assign a_op   = cnt_ff[0] ? {a_sel[47], a_sel[47:24]} : {1'b0, a_sel[23:0]};

   always_comb begin
      unique case (ap_col)
         2'd0:    p_op = {cmd_ff.px[31], cmd_ff.px};
         2'd1:    p_op = {cmd_ff.py[31], cmd_ff.py};
         2'd2:    p_op = {cmd_ff.pz[31], cmd_ff.pz};
         default: p_op = P_ONE;
      endcase
   end

   assign contrib = prd_idx_ff[0] ? ({{25{prd_ff[57]}}, prd_ff} <<< 24)
                                  : {{25{prd_ff[57]}}, prd_ff};
   assign sum_in  = ((prd_idx_ff[2:0] == 3'd0) ? '0 : sum_ff) + contrib;
   assign shifted = sum_in >>> FRAC_BITS;
   assign row_sat = (shifted > SAT_HI) ? 32'sh7fffffff :
                    (shifted < SAT_LO) ? 32'sh80000000 : shifted[31:0];

   always_ff @(posedge clock) begin
      if (cmd_load) cmd_ff <= q_cmd;
      rd_idx_ff  <= cnt_ff[3:0];
      mul_idx_ff <= rd_idx_ff;
      mul_ff     <= $signed({1'b0, cmd_ff.weight}) * $signed(rd_data_ff);
      prd_idx_ff <= cnt_ff;
      prd_ff     <= a_op * p_op;
      if (prd_vld_ff) sum_ff <= sum_in;
      if (prd_vld_ff && prd_idx_ff[2:0] == 3'd7) res_ff[prd_idx_ff[4:3]] <= row_sat;
      if (out_load) begin
         rsp_out_x_ff <= res_ff[0];
         rsp_out_y_ff <= res_ff[1];
         rsp_out_z_ff <= res_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_out_x_ff;
   assign rsp_out_y = rsp_out_y_ff;
   assign rsp_out_z = rsp_out_z_ff;

endmodule

// ----- sv/linear_blend_skinning_top.sv -----
// A load is written to bone memory straight from the idle state; an influence walks the 16 bone
// words through the single memory read port; a last influence then adds 24 product
// steps through one 25x33 multiplier before the result is loaded into the output register.
// A 2-deep request queue lets the front keep accepting while the back end works.
// Synchronous reset clears the queue, sequencer, blend matrix and output valid;
// bone memory is not cleared.
module linear_blend_skinning_top #(
   parameter int BONE_COUNT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [7:0]           req_bone_index,
   input  logic [3:0]           req_matrix_entry,
   input  logic signed [31:0]   req_entry_value,
   input  logic [15:0]          req_weight,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic                 req_last_influence,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z
);

   logic             q_valid, q_pop;
   lbs_pkg::cmd_type q_cmd;

   lbs_front #(.BONE_COUNT(BONE_COUNT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_bone_index,
      .req_matrix_entry, .req_entry_value, .req_weight, .req_pos_x, .req_pos_y,
      .req_pos_z, .req_last_influence, .q_valid, .q_cmd, .q_pop
   );

   lbs_back #(.BONE_COUNT(BONE_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .rsp_valid, .rsp_ready,
      .rsp_out_x, .rsp_out_y, .rsp_out_z
   );

   a_pop_valid: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("pending response lost");

endmodule

// ----- tb/linear_blend_skinning_top_test.sv -----
`timescale 1ns / 100ps

module linear_blend_skinning_top_test;

   localparam int FRAC     = 16;
   localparam int STALL_MAX = 5000;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = lbs_pkg::OP_LOAD;
   logic [7:0]         req_bone_index = '0;
   logic [3:0]         req_matrix_entry = '0;
   logic signed [31:0] req_entry_value = '0;
   logic [15:0]        req_weight = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic               req_last_influence = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;

   linear_blend_skinning_top dut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [31:0]        bone_words [0:4095];
   bit                 word_written [0:4095];
   logic signed [47:0] blend_acc [0:15];
   byte unsigned       loaded_bones [$];
   vertex_type         skinned_due [$];

   int  mismatches = 0;
   int  items_sent = 0;
   bit  steady = 1'b0;
   bit  hold_go = 1'b0;
   int  hold_cycles = 0;
   bit  took_req = 1'b0;
   bit  took_rsp = 1'b0;
   int  stall_count = 0;

   function automatic logic signed [31:0] blend_row(int r, vertex_type p);
      logic signed [95:0] sum;
      logic signed [95:0] a;
      logic signed [95:0] pv [0:3];
      pv[0] = 96'(p.x);
      pv[1] = 96'(p.y);
      pv[2] = 96'(p.z);
      pv[3] = 96'sd1 <<< FRAC;
      sum = '0;
      for (int c = 0; c < 4; c++) begin
         a = 96'(blend_acc[c*4 + r]);
         sum += a * pv[c];
      end
      sum = sum >>> FRAC;
      if (sum > 96'sd2147483647) return 32'sh7fffffff;
      if (sum < -96'sd2147483648) return 32'sh80000000;
      return sum[31:0];
   endfunction

   task automatic predict_skin(lbs_pkg::op_type op, logic [7:0] bone, logic [3:0] entry,
                               logic [31:0] value, logic [15:0] w, vertex_type p,
                               logic last);
      logic signed [63:0] m;
      logic signed [63:0] t;
      logic signed [63:0] ws;
      vertex_type         v;
      bit                 full;
      if (op == lbs_pkg::OP_LOAD) begin
         bone_words[{bone, entry}] = value;
         word_written[{bone, entry}] = 1'b1;
         full = 1'b1;
         for (int i = 0; i < 16; i++) full &= word_written[{bone, 4'(i)}];
         if (full && !(bone inside {loaded_bones})) loaded_bones = {loaded_bones, bone};
         return;
      end
      ws = {48'b0, w};
      for (int i = 0; i < 16; i++) begin
         m = 64'($signed(bone_words[{bone, 4'(i)}]));
         t = 64'(blend_acc[i]) + ((ws * m) >>> 15);
         if (t > 64'sh7fff_ffff_ffff) t = 64'sh7fff_ffff_ffff;
         if (t < -64'sh8000_0000_0000) t = -64'sh8000_0000_0000;
         blend_acc[i] = t[47:0];
      end
      if (!last) return;
      v.x = blend_row(0, p);
      v.y = blend_row(1, p);
      v.z = blend_row(2, p);
      skinned_due = {skinned_due, v};
      for (int i = 0; i < 16; i++) blend_acc[i] = '0;
   endtask

   // called at a rising edge; returns at the edge where the request is taken
   task automatic send_request(lbs_pkg::op_type op, logic [7:0] bone, logic [3:0] entry,
                               logic [31:0] value, logic [15:0] w, vertex_type p,
                               logic last);
      bit taken;
      if (!steady && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= op;
      req_bone_index     <= bone;
      req_matrix_entry   <= entry;
      req_entry_value    <= value;
      req_weight         <= w;
      req_pos_x          <= p.x;
      req_pos_y          <= p.y;
      req_pos_z          <= p.z;
      req_last_influence <= last;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      predict_skin(op, bone, entry, value, w, p, last);
      items_sent++;
   endtask

   function automatic logic [31:0] rand_word();
      if ($urandom_range(2) == 0) return $urandom();
      return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type p;
      p.x = rand_word();
      p.y = rand_word();
      p.z = rand_word();
      return p;
   endfunction

   function automatic logic [15:0] rand_weight();
      if ($urandom_range(4) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 32768));
   endfunction

   task automatic load_bone(logic [7:0] bone, int style);
      logic [31:0] value;
      for (int e = 0; e < 16; e++) begin
         case (style)
            0: value = (e % 5 == 0) ? 32'h0001_0000 : 32'h0;   // identity
            1: value = e[0] ? 32'h7fff_ffff : 32'h8000_0000;
            default: value = rand_word();
         endcase
         send_request(lbs_pkg::OP_LOAD, bone, 4'(e), value, 16'($urandom()), rand_vertex(),
                      1'($urandom()));
      end
   endtask

   task automatic send_vertex(int n_infl);
      byte unsigned b;
      for (int k = 0; k < n_infl; k++) begin
         b = loaded_bones[$urandom_range(0, loaded_bones.size() - 1)];
         send_request(lbs_pkg::OP_BLEND, b, 4'($urandom()), $urandom(), rand_weight(),
                      rand_vertex(), k == n_infl - 1);
      end
   endtask

   task automatic test_bone_table();
      load_bone(8'h00, 0);
      load_bone(8'hff, 1);
      load_bone(8'h55, 2);
      load_bone(8'haa, 2);
   endtask

   task automatic test_directed_blend();
      vertex_type p;
      p.x = 32'sh0002_8000; p.y = -32'sh0001_0000; p.z = 32'sh0000_0001;
      send_request(lbs_pkg::OP_BLEND, 8'h00, '0, '0, 16'h8000, p, 1'b1);   // identity, weight one
      send_request(lbs_pkg::OP_BLEND, 8'h00, '0, '0, 16'h0000, p, 1'b1);   // zero weight
      p.x = 32'sh7fff_ffff; p.y = 32'sh8000_0000; p.z = 32'sh7fff_ffff;
      // weight above one, saturates
      send_request(lbs_pkg::OP_BLEND, 8'hff, '0, '0, 16'hffff, p, 1'b1);
      send_request(lbs_pkg::OP_BLEND, 8'hff, '0, '0, 16'h0001, p, 1'b1);
      // positions on non-last influences are ignored
      send_request(lbs_pkg::OP_BLEND, 8'h55, '0, '0, 16'h4000, rand_vertex(), 1'b0);
      send_request(lbs_pkg::OP_BLEND, 8'haa, '0, '0, 16'h2000, rand_vertex(), 1'b0);
      send_request(lbs_pkg::OP_BLEND, 8'h00, '0, '0, 16'h2000, p, 1'b1);
      // load items ignore weight, positions and last mark
      send_request(lbs_pkg::OP_LOAD, 8'haa, 4'hf, 32'h0000_8000, 16'hffff, p, 1'b1);
      send_request(lbs_pkg::OP_BLEND, 8'haa, '0, '0, 16'h8000, rand_vertex(), 1'b1);
      send_request(lbs_pkg::OP_BLEND, 8'hff, '0, '0, 16'hffff, p, 1'b0);
      send_request(lbs_pkg::OP_BLEND, 8'hff, '0, '0, 16'hffff, p, 1'b0);
      p.x = 32'sh8000_0000; p.y = 32'sh7fff_ffff; p.z = 32'sh8000_0000;
      send_request(lbs_pkg::OP_BLEND, 8'hff, '0, '0, 16'hffff, p, 1'b1);
   endtask

   task automatic test_random_stream();
      int target;
      int r;
      target = items_sent + 750;
      while (items_sent < target) begin
         steady = (items_sent > target - 300) && (items_sent < target - 150);
         r = $urandom_range(99);
         if (r < 15)
            send_request(lbs_pkg::OP_LOAD, 8'($urandom()), 4'($urandom()), rand_word(),
                         16'($urandom()), rand_vertex(), 1'($urandom()));
         else if (r < 18)
            load_bone(8'($urandom()), 2);
         else
            send_vertex($urandom_range(1, 4));
      end
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      req_valid <= 1'b0;
      steady = 1'b1;
      @(negedge clock);
      hold_go = 1'b1;
      @(posedge clock);
      repeat (30) send_vertex(1);
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (hold_go) begin
         hold_go = 1'b0;
         hold_cycles <= 400;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 26);
      end
   end

   // values are stable mid-cycle, so check there
   always @(negedge clock) begin
      vertex_type e;
      took_req = !reset && req_valid && req_ready;
      took_rsp = !reset && rsp_valid && rsp_ready;
      if (took_rsp) begin
         if (skinned_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected vertex out %0d %0d %0d", rsp_out_x, rsp_out_y, rsp_out_z);
         end else begin
            e = skinned_due.pop_front();
            if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_z !== e.z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("vertex mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           e.x, e.y, e.z, rsp_out_x, rsp_out_y, rsp_out_z);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || took_req || took_rsp) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_MAX) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 16; i++) blend_acc[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bone_table();
      test_directed_blend();
      test_random_stream();
      test_backpressure();
      req_valid <= 1'b0;
      while (skinned_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && skinned_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/lbs_pkg.sv
sv/lbs_front.sv
sv/lbs_back.sv
sv/linear_blend_skinning_top.sv
tb/linear_blend_skinning_top_test.sv
